// File: rtl/stmes_pkg.sv
package stmes_pkg;

    localparam int unsigned DATA_W              = 32;
    localparam int unsigned COEF_W              = 31;
    localparam int unsigned ACC_W               = 48;
    localparam int unsigned FRAC_W              = 16;
    localparam int unsigned CFG_IDX_W           = 3;
    localparam int unsigned TIME_STEP_SHIFT_DEF = 14;
    localparam int unsigned N_STEPS             = 19;
    localparam int unsigned STEP_W              = $clog2(N_STEPS + 1);

    localparam logic [COEF_W-1:0] GEAR_RATIO_RST = COEF_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_TORSION_STIFFNESS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORSION_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR_RATIO        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PINION_RADIUS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RACK_STIFFNESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RACK_DAMPING      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_STEP_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_STEP_GAIN  = 3'd7;

    typedef enum logic [3:0] {
        A_DTH, A_DOM, A_THC, A_OMC, A_MOTOR, A_X, A_V, A_NSW, A_F, A_NCOL
    } t_a_sel;

    typedef enum logic [2:0] {
        B_KS, B_KD, B_PR, B_GR, B_KRS, B_KRD, B_WSG, B_CSG
    } t_b_sel;

    typedef enum logic [3:0] {
        D_NONE, D_ACC, D_TTB, D_X, D_V, D_TAS, D_F, D_TLOAD,
        D_WSPD, D_WANG, D_CSPD, D_CANG
    } t_dst;

    typedef struct packed {
        logic   load;
        logic   out_load;
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_dst   dst;
    } t_cmd;

endpackage

// File: rtl/stmes_ctrl.sv
module stmes_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output stmes_pkg::t_cmd   o_cmd
);
    import stmes_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                r_busy;
    logic                r_out_valid;
    logic                accept;
    logic                last;
    logic                slot_free;

    assign accept    = (r_state == S_IDLE) && i_valid;
    assign last      = (r_state == S_RUN) && (r_step == STEP_W'(N_STEPS));
    assign slot_free = !r_out_valid || !i_stall;

    always_comb begin
        o_cmd          = '0;
        o_cmd.a_sel    = A_DTH;
        o_cmd.b_sel    = B_PR;
        o_cmd.dst      = D_NONE;
        o_cmd.load     = accept;
        o_cmd.out_load = last && slot_free;
        if (r_state == S_RUN) begin
            case (r_step)
                5'd1:  begin o_cmd.a_sel = A_DTH;   o_cmd.b_sel = B_KS;  end
                5'd2:  begin o_cmd.a_sel = A_DOM;   o_cmd.b_sel = B_KD;  o_cmd.dst = D_ACC;  end
                5'd3:  begin o_cmd.a_sel = A_THC;   o_cmd.b_sel = B_PR;  o_cmd.dst = D_TTB;  end
                5'd4:  begin o_cmd.a_sel = A_OMC;   o_cmd.b_sel = B_PR;  o_cmd.dst = D_X;    end
                5'd5:  begin o_cmd.a_sel = A_MOTOR; o_cmd.b_sel = B_GR;  o_cmd.dst = D_V;    end
                5'd6:  begin o_cmd.a_sel = A_X;     o_cmd.b_sel = B_KRS; o_cmd.dst = D_TAS;  end
                5'd7:  begin o_cmd.a_sel = A_V;     o_cmd.b_sel = B_KRD; o_cmd.dst = D_ACC;  end
                5'd8:  begin o_cmd.a_sel = A_NSW;   o_cmd.b_sel = B_WSG; o_cmd.dst = D_F;    end
                5'd9:  begin o_cmd.a_sel = A_F;     o_cmd.b_sel = B_PR;  o_cmd.dst = D_WSPD; end
                5'd10: o_cmd.dst = D_TLOAD;
                5'd11: o_cmd.dst = D_WANG;
                5'd12: begin o_cmd.a_sel = A_NCOL;  o_cmd.b_sel = B_CSG; end
                5'd13: o_cmd.dst = D_CSPD;
                5'd14: begin o_cmd.a_sel = A_OMC;   o_cmd.b_sel = B_PR;  o_cmd.dst = D_CANG; end
                5'd15: begin o_cmd.a_sel = A_THC;   o_cmd.b_sel = B_PR;  o_cmd.dst = D_V;    end
                5'd16: begin o_cmd.a_sel = A_V;     o_cmd.b_sel = B_KRD; o_cmd.dst = D_X;    end
                5'd17: begin o_cmd.a_sel = A_X;     o_cmd.b_sel = B_KRS; o_cmd.dst = D_ACC;  end
                5'd18: o_cmd.dst = D_F;
                default: o_cmd.dst = D_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (last && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_step  <= STEP_W'(1);
                        r_busy  <= 1'b1;
                    end
                end
                S_RUN: begin
                    if (last) begin
                        if (slot_free) begin
                            r_state     <= S_IDLE;
                            r_step      <= '0;
                            r_busy      <= 1'b0;
                        end
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
            endcase
        end
    end

    assign o_stall = r_busy;
    assign o_valid = r_out_valid;

endmodule

// File: rtl/stmes_dp.sv
module stmes_dp #(
    parameter int unsigned TIME_STEP_SHIFT = stmes_pkg::TIME_STEP_SHIFT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stmes_pkg::t_cmd                      i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [stmes_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [stmes_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [stmes_pkg::DATA_W-1:0]  i_hand_torque,
    input  logic signed [stmes_pkg::DATA_W-1:0]  i_motor_torque,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_wheel_angle,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_wheel_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_column_angle,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_column_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_position,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_force,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_torsion_torque,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_assist_torque
);
    import stmes_pkg::*;

    localparam int unsigned PROD_W = 2 * DATA_W;

    // configuration
    logic [COEF_W-1:0]  r_ks, r_kd, r_gr, r_pr, r_krs, r_krd;
    logic [DATA_W-1:0]  r_wsg, r_csg;

    // plant state, Q32.16
    logic [ACC_W-1:0]   r_wang, r_wspd, r_cang, r_cspd;

    // per-transaction working registers
    logic [DATA_W-1:0]  r_hand, r_motor, r_dth, r_dom;
    logic [DATA_W-1:0]  r_ttb, r_x, r_v, r_tas, r_f, r_tload;
    logic [DATA_W-1:0]  r_net_sw, r_net_col;
    logic [ACC_W-1:0]   r_acc;
    logic [PROD_W-1:0]  r_prod;

    logic signed [DATA_W-1:0]   a_op;
    logic [DATA_W-1:0]          b_op;
    logic signed [PROD_W:0]     prod;
    logic [ACC_W-1:0]           sum48;
    logic [ACC_W-1:0]           spd_src;
    logic [ACC_W-1:0]           spd_sh;

    always_comb begin
        unique case (i_cmd.a_sel)
            A_DTH:   a_op = r_dth;
            A_DOM:   a_op = r_dom;
            A_THC:   a_op = r_cang[ACC_W-1:FRAC_W];
            A_OMC:   a_op = r_cspd[ACC_W-1:FRAC_W];
            A_MOTOR: a_op = r_motor;
            A_X:     a_op = r_x;
            A_V:     a_op = r_v;
            A_NSW:   a_op = r_net_sw;
            A_F:     a_op = r_f;
            A_NCOL:  a_op = r_net_col;
            default: a_op = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.b_sel)
            B_KS:  b_op = {1'b0, r_ks};
            B_KD:  b_op = {1'b0, r_kd};
            B_PR:  b_op = {1'b0, r_pr};
            B_GR:  b_op = {1'b0, r_gr};
            B_KRS: b_op = {1'b0, r_krs};
            B_KRD: b_op = {1'b0, r_krd};
            B_WSG: b_op = r_wsg;
            B_CSG: b_op = r_csg;
        endcase
    end

    assign prod    = a_op * $signed({1'b0, b_op});
    assign sum48   = r_acc + r_prod[ACC_W-1:0];
    assign spd_src = (i_cmd.dst == D_WANG) ? r_wspd : r_cspd;
    assign spd_sh  = ACC_W'($signed(spd_src) >>> TIME_STEP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ks  <= '0;
            r_kd  <= '0;
            r_gr  <= GEAR_RATIO_RST;
            r_pr  <= '0;
            r_krs <= '0;
            r_krd <= '0;
            r_wsg <= '0;
            r_csg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TORSION_STIFFNESS: r_ks  <= i_cfg_data[COEF_W-1:0];
                CFG_TORSION_DAMPING:   r_kd  <= i_cfg_data[COEF_W-1:0];
                CFG_GEAR_RATIO:        r_gr  <= i_cfg_data[COEF_W-1:0];
                CFG_PINION_RADIUS:     r_pr  <= i_cfg_data[COEF_W-1:0];
                CFG_RACK_STIFFNESS:    r_krs <= i_cfg_data[COEF_W-1:0];
                CFG_RACK_DAMPING:      r_krd <= i_cfg_data[COEF_W-1:0];
                CFG_WHEEL_STEP_GAIN:   r_wsg <= i_cfg_data;
                CFG_COLUMN_STEP_GAIN:  r_csg <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wang <= '0;
            r_wspd <= '0;
            r_cang <= '0;
            r_cspd <= '0;
        end else begin
            unique case (i_cmd.dst)
                D_WSPD:  r_wspd <= r_wspd + r_prod[PROD_W-1:FRAC_W];
                D_WANG:  r_wang <= r_wang + spd_sh;
                D_CSPD:  r_cspd <= r_cspd + r_prod[PROD_W-1:FRAC_W];
                D_CANG:  r_cang <= r_cang + spd_sh;
                default: r_wang <= r_wang;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= prod[PROD_W-1:0];
        r_net_sw  <= r_hand - r_ttb;
        r_net_col <= r_ttb + r_tas - r_tload;
        if (i_cmd.load) begin
            r_hand  <= i_hand_torque;
            r_motor <= i_motor_torque;
            r_dth   <= r_wang[ACC_W-1:FRAC_W] - r_cang[ACC_W-1:FRAC_W];
            r_dom   <= r_wspd[ACC_W-1:FRAC_W] - r_cspd[ACC_W-1:FRAC_W];
        end
        unique case (i_cmd.dst)
            D_ACC:   r_acc   <= r_prod[ACC_W-1:0];
            D_TTB:   r_ttb   <= sum48[ACC_W-1:FRAC_W];
            D_X:     r_x     <= r_prod[ACC_W-1:FRAC_W];
            D_V:     r_v     <= r_prod[ACC_W-1:FRAC_W];
            D_TAS:   r_tas   <= r_prod[ACC_W-1:FRAC_W];
            D_F:     r_f     <= sum48[ACC_W-1:FRAC_W];
            D_TLOAD: r_tload <= r_prod[ACC_W-1:FRAC_W];
            default: r_acc   <= r_acc;
        endcase
        if (i_cmd.out_load) begin
            o_wheel_angle    <= r_wang[ACC_W-1:FRAC_W];
            o_wheel_speed    <= r_wspd[ACC_W-1:FRAC_W];
            o_column_angle   <= r_cang[ACC_W-1:FRAC_W];
            o_column_speed   <= r_cspd[ACC_W-1:FRAC_W];
            o_rack_position  <= r_x;
            o_rack_speed     <= r_v;
            o_rack_force     <= r_f;
            o_torsion_torque <= r_ttb;
            o_assist_torque  <= r_tas;
        end
    end

endmodule

// File: rtl/steering_two_mass_euler_step.sv
// Two-mass steering plant, one semi-implicit Euler step per transaction.
// Input channel: i_valid / o_stall carry hand and motor torque (Q16.16).
// A transaction is taken on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry the new angles and speeds, rack
// position, speed and force, the pre-update torsion torque and assist torque.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data, write only, while idle.
// One 32x33 multiplier is shared by the 14 products of a step, scheduled by
// a fixed sequencer; a new transaction is taken the cycle after the result is
// registered, so the block never takes a new transaction while a step is in
// progress.
// The result register is separate from the datapath: a new transaction is
// accepted while the previous result waits; if it is still waiting when the
// next one finishes, the sequencer holds on its last step until i_stall drops.
// Reset (synchronous, active low) clears the plant state to zero, sets gear
// ratio to 1.0 and all other coefficients to zero, and drops o_valid.
module steering_two_mass_euler_step #(
    parameter int unsigned TIME_STEP_SHIFT = stmes_pkg::TIME_STEP_SHIFT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [stmes_pkg::DATA_W-1:0]  i_hand_torque,
    input  logic signed [stmes_pkg::DATA_W-1:0]  i_motor_torque,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_wheel_angle,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_wheel_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_column_angle,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_column_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_position,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_speed,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_rack_force,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_torsion_torque,
    output logic signed [stmes_pkg::DATA_W-1:0]  o_assist_torque,
    input  logic                                 i_cfg_we,
    input  logic [stmes_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [stmes_pkg::DATA_W-1:0]         i_cfg_data
);
    import stmes_pkg::*;

    t_cmd cmd;

    stmes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    stmes_dp #(
        .TIME_STEP_SHIFT (TIME_STEP_SHIFT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_hand_torque    (i_hand_torque),
        .i_motor_torque   (i_motor_torque),
        .o_wheel_angle    (o_wheel_angle),
        .o_wheel_speed    (o_wheel_speed),
        .o_column_angle   (o_column_angle),
        .o_column_speed   (o_column_speed),
        .o_rack_position  (o_rack_position),
        .o_rack_speed     (o_rack_speed),
        .o_rack_force     (o_rack_force),
        .o_torsion_torque (o_torsion_torque),
        .o_assist_torque  (o_assist_torque)
    );

endmodule
